@@ design/ppt_pkg.sv @@
// Shared widths, result word type and event codes for the pulse peak/trough detector.
package ppt_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int INDEX_WIDTH  = 16;

    // Result queue depth; one item may push two words
    localparam int FIFO_DEPTH   = 4;
    localparam int PTR_WIDTH    = $clog2(FIFO_DEPTH);
    localparam int COUNT_WIDTH  = $clog2(FIFO_DEPTH + 1);

    localparam logic KIND_PEAK   = 1'b0;
    localparam logic KIND_TROUGH = 1'b1;

    typedef struct packed {
        logic                   kind;
        logic [INDEX_WIDTH-1:0] position;
        logic                   last;
    } result_t;

endpackage

@@ design/pulse_peak_trough_detector.sv @@
// Flow: an accepted word is held in the input register, then processed, and its results
// are written into the result queue, whose head is presented with event_valid.
// Throughput: one sample per cycle; a sample that closes a region pushes up to two
// words into a four-entry result queue, and the input stalls while fewer than two
// entries are free. Reset (rst_n low, asynchronous) clears all tracking state and the
// queue; a word with record_end set returns the tracking state to reset after it.
module pulse_peak_trough_detector
    import ppt_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic signed [SAMPLE_WIDTH-1:0] average,
    input  logic                           record_end,
    output logic                           event_valid,
    input  logic                           event_stall,
    output logic                           event_kind,
    output logic [INDEX_WIDTH-1:0]         position,
    output logic                           last
);

    // Input register
    logic                           stage_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] stage_sample_reg;
    logic signed [SAMPLE_WIDTH-1:0] stage_average_reg;
    logic                           stage_end_reg;

    // Tracking state
    logic signed [SAMPLE_WIDTH-1:0] prev_sample_reg, prev_sample_next;
    logic signed [SAMPLE_WIDTH-1:0] prev_average_reg, prev_average_next;
    logic [INDEX_WIDTH-1:0]         counter_reg, counter_next;
    logic                           in_region_reg, in_region_next;
    logic signed [SAMPLE_WIDTH-1:0] best_value_reg, best_value_next;
    logic [INDEX_WIDTH-1:0]         best_index_reg, best_index_next;
    logic signed [SAMPLE_WIDTH-1:0] after_value_reg, after_value_next;
    logic [INDEX_WIDTH-1:0]         after_index_reg, after_index_next;
    logic                           after_valid_reg, after_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] trough_value_reg, trough_value_next;
    logic [INDEX_WIDTH-1:0]         trough_index_reg, trough_index_next;
    logic                           have_peak_reg, have_peak_next;
    logic                           has_prev_reg, has_prev_next;

    // Result queue
    result_t                 fifo_reg [FIFO_DEPTH];
    logic [PTR_WIDTH-1:0]    wr_ptr_reg;
    logic [PTR_WIDTH-1:0]    rd_ptr_reg;
    logic [COUNT_WIDTH-1:0]  count_reg;

    logic                    advance;
    logic                    room_two;
    logic                    emit_peak;
    logic                    emit_trough;
    logic [INDEX_WIDTH-1:0]  peak_pos;
    logic [INDEX_WIDTH-1:0]  trough_pos;
    logic                    pop;
    logic [1:0]              push_count;

    // Handshake and queue control
    assign room_two     = (count_reg <= COUNT_WIDTH'(FIFO_DEPTH - 2));
    assign advance      = stage_valid_reg && room_two;
    assign sample_stall = stage_valid_reg && !room_two;
    assign event_valid  = (count_reg != '0);
    assign pop          = event_valid && !event_stall;
    assign push_count   = advance ? ({1'b0, emit_peak} + {1'b0, emit_trough}) : 2'd0;

    assign event_kind = fifo_reg[rd_ptr_reg].kind;
    assign position   = fifo_reg[rd_ptr_reg].position;
    assign last       = fifo_reg[rd_ptr_reg].last;

    // Input register load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (!sample_stall)
        begin
            stage_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && !sample_stall)
        begin
            stage_sample_reg  <= sample;
            stage_average_reg <= average;
            stage_end_reg     <= record_end;
        end
    end

    // Region tracking for the pair (previous sample, current sample)
    always_comb
    begin
        logic signed [SAMPLE_WIDTH-1:0] x;
        logic [INDEX_WIDTH-1:0]         k;
        logic                           rise;
        logic                           fall;

        x    = prev_sample_reg;
        k    = counter_reg - INDEX_WIDTH'(1);
        rise = (prev_average_reg > x) && (stage_average_reg < stage_sample_reg);
        fall = (prev_average_reg < x) && (stage_average_reg > stage_sample_reg);

        in_region_next    = in_region_reg;
        best_value_next   = best_value_reg;
        best_index_next   = best_index_reg;
        after_value_next  = after_value_reg;
        after_index_next  = after_index_reg;
        after_valid_next  = after_valid_reg;
        trough_value_next = trough_value_reg;
        trough_index_next = trough_index_reg;
        have_peak_next    = have_peak_reg;
        emit_peak         = 1'b0;
        emit_trough       = 1'b0;
        peak_pos          = best_index_reg;
        trough_pos        = trough_index_reg;

        if (has_prev_reg)
        begin
            if (in_region_reg)
            begin
                // New region maximum: fold the dip behind the old best into the trough
                if (x >= best_value_reg)
                begin
                    if (after_valid_reg && (after_value_reg <= trough_value_next))
                    begin
                        trough_value_next = after_value_reg;
                        trough_index_next = after_index_reg;
                    end
                    if (x <= trough_value_next)
                    begin
                        trough_value_next = x;
                        trough_index_next = k;
                    end
                    best_value_next  = x;
                    best_index_next  = k;
                    after_valid_next = 1'b0;
                end
                else if (!after_valid_reg || (x <= after_value_reg))
                begin
                    after_value_next = x;
                    after_index_next = k;
                    after_valid_next = 1'b1;
                end

                // Region closes: report peak, then trough since previous peak
                if (fall)
                begin
                    emit_peak   = 1'b1;
                    emit_trough = have_peak_reg;
                    peak_pos    = best_index_next;
                    trough_pos  = trough_index_next;
                    trough_value_next = best_value_next;
                    trough_index_next = best_index_next;
                    if (after_valid_next && (after_value_next <= best_value_next))
                    begin
                        trough_value_next = after_value_next;
                        trough_index_next = after_index_next;
                    end
                    after_valid_next = 1'b0;
                    have_peak_next   = 1'b1;
                    in_region_next   = 1'b0;
                end
            end
            else
            begin
                if (x <= trough_value_reg)
                begin
                    trough_value_next = x;
                    trough_index_next = k;
                end
                if (rise)
                begin
                    best_value_next  = x;
                    best_index_next  = k;
                    after_valid_next = 1'b0;
                    in_region_next   = 1'b1;
                end
            end
        end

        prev_sample_next  = stage_sample_reg;
        prev_average_next = stage_average_reg;
        has_prev_next     = 1'b1;
        counter_next      = counter_reg + INDEX_WIDTH'(1);

        // End of record: everything back to reset, open region dropped
        if (stage_end_reg)
        begin
            prev_sample_next  = '0;
            prev_average_next = '0;
            has_prev_next     = 1'b0;
            counter_next      = '0;
            in_region_next    = 1'b0;
            best_value_next   = '0;
            best_index_next   = '0;
            after_value_next  = '0;
            after_index_next  = '0;
            after_valid_next  = 1'b0;
            trough_value_next = '0;
            trough_index_next = '0;
            have_peak_next    = 1'b0;
        end
    end

    // Tracking state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg  <= '0;
            prev_average_reg <= '0;
            counter_reg      <= '0;
            in_region_reg    <= 1'b0;
            best_value_reg   <= '0;
            best_index_reg   <= '0;
            after_value_reg  <= '0;
            after_index_reg  <= '0;
            after_valid_reg  <= 1'b0;
            trough_value_reg <= '0;
            trough_index_reg <= '0;
            have_peak_reg    <= 1'b0;
            has_prev_reg     <= 1'b0;
        end
        else if (advance)
        begin
            prev_sample_reg  <= prev_sample_next;
            prev_average_reg <= prev_average_next;
            counter_reg      <= counter_next;
            in_region_reg    <= in_region_next;
            best_value_reg   <= best_value_next;
            best_index_reg   <= best_index_next;
            after_value_reg  <= after_value_next;
            after_index_reg  <= after_index_next;
            after_valid_reg  <= after_valid_next;
            trough_value_reg <= trough_value_next;
            trough_index_reg <= trough_index_next;
            have_peak_reg    <= have_peak_next;
            has_prev_reg     <= has_prev_next;
        end
    end

    // Result queue storage: peak at the write pointer, trough right behind it
    always_ff @(posedge clk)
    begin
        if (advance && emit_peak)
        begin
            fifo_reg[wr_ptr_reg] <= '{kind: KIND_PEAK, position: peak_pos,
                                      last: !emit_trough};
        end
        if (advance && emit_trough)
        begin
            fifo_reg[wr_ptr_reg + PTR_WIDTH'(1)] <= '{kind: KIND_TROUGH,
                                                      position: trough_pos, last: 1'b1};
        end
    end

    // Result queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_WIDTH'(push_count);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_WIDTH'(1);
            end
            count_reg <= count_reg + COUNT_WIDTH'(push_count) - COUNT_WIDTH'(pop);
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_WIDTH'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_trough_after_peak: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit_trough) |-> (emit_peak && have_peak_reg))
        else $error("trough emitted without a peak");

    a_record_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stage_end_reg) |=> (!in_region_reg && !has_prev_reg && !have_peak_reg
                                        && counter_reg == '0))
        else $error("record end did not clear tracking state");
`endif

endmodule
